>>> rtl/point_rigid_transform_macros.svh
// Assertion helpers for the point transform RTL.
`ifndef POINT_RIGID_TRANSFORM_MACROS_SVH
`define POINT_RIGID_TRANSFORM_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PRT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("point transform: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define PRT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("point transform: next-cycle check failed");

`endif

>>> rtl/prt_pkg.sv
`timescale 1ns / 1ps

package prt_pkg;

  localparam int COORD_W = 32;
  localparam int COEF_W  = 16;
  localparam int MAT_FRAC = 14;
  localparam int ROW_W   = 3 * COEF_W;

  // point minus translation, kept one bit wider so it never wraps
  localparam int D_W    = COORD_W + 1;
  localparam int PROD_W = D_W + COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SHR_W  = SUM_W - MAT_FRAC;
  localparam int ACC_W  = SHR_W + 1;

  localparam int APB_DW = 64;
  localparam int APB_AW = 6;

  localparam logic OP_FWD  = 1'b0;
  localparam logic OP_BACK = 1'b1;

  localparam logic [2:0] REG_ROW_ZERO = 3'd0;
  localparam logic [2:0] REG_ROW_ONE  = 3'd1;
  localparam logic [2:0] REG_ROW_TWO  = 3'd2;
  localparam logic [2:0] REG_SHIFT_X  = 3'd3;
  localparam logic [2:0] REG_SHIFT_Y  = 3'd4;
  localparam logic [2:0] REG_SHIFT_Z  = 3'd5;

  // identity matrix after reset
  localparam logic [ROW_W-1:0] ROW_ZERO_RST = 48'd16384;
  localparam logic [ROW_W-1:0] ROW_ONE_RST  = 48'd1073741824;
  localparam logic [ROW_W-1:0] ROW_TWO_RST  = 48'd70368744177664;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic signed [COORD_W-1:0] z_in;
  } point_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic signed [COORD_W-1:0] z_out;
    logic                      clipped;
  } point_out_t;

endpackage

>>> rtl/point_rigid_transform.sv
`timescale 1ns / 1ps
// Pipeline: five register stages (diff, multiply, sum, shift/add, saturate); done_o
//   is high when the saturate stage holds a result.
// Throughput: one item per cycle; busy stays low, the result side cannot stall.
// Reset: pipeline valid bits clear; matrix returns to identity, translation to zero.
`include "point_rigid_transform_macros.svh"

module point_rigid_transform (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  prt_pkg::point_in_t           in_i,
  output logic                         done_o,
  output prt_pkg::point_out_t          result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prt_pkg::APB_AW-1:0]   paddr,
  input  logic [prt_pkg::APB_DW-1:0]   pwdata,
  output logic [prt_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import prt_pkg::*;

  // ---------------- configuration registers ----------------
  logic [ROW_W-1:0]          row_q   [3];
  logic signed [COORD_W-1:0] shift_q [3];
  logic [2:0]                reg_idx;
  logic                      cfg_we;

  assign reg_idx = paddr[APB_AW-1:3];
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0]   <= ROW_ZERO_RST;
      row_q[1]   <= ROW_ONE_RST;
      row_q[2]   <= ROW_TWO_RST;
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_ROW_ZERO: row_q[0]   <= pwdata[ROW_W-1:0];
        REG_ROW_ONE:  row_q[1]   <= pwdata[ROW_W-1:0];
        REG_ROW_TWO:  row_q[2]   <= pwdata[ROW_W-1:0];
        REG_SHIFT_X:  shift_q[0] <= pwdata[COORD_W-1:0];
        REG_SHIFT_Y:  shift_q[1] <= pwdata[COORD_W-1:0];
        REG_SHIFT_Z:  shift_q[2] <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_ZERO: prdata = {{(APB_DW-ROW_W){1'b0}}, row_q[0]};
      REG_ROW_ONE:  prdata = {{(APB_DW-ROW_W){1'b0}}, row_q[1]};
      REG_ROW_TWO:  prdata = {{(APB_DW-ROW_W){1'b0}}, row_q[2]};
      REG_SHIFT_X:  prdata = {{(APB_DW-COORD_W){1'b0}}, shift_q[0]};
      REG_SHIFT_Y:  prdata = {{(APB_DW-COORD_W){1'b0}}, shift_q[1]};
      REG_SHIFT_Z:  prdata = {{(APB_DW-COORD_W){1'b0}}, shift_q[2]};
      default:      prdata = '0;
    endcase
  end

  // matrix entries, column 0 in the low bits of each row
  logic signed [COEF_W-1:0] mat [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mat[r][c] = row_q[r][COEF_W*c +: COEF_W];
      end
    end
  end

  // ---------------- stage 1: translate (forward) ----------------
  logic                      accept;
  logic signed [COORD_W-1:0] pt [3];
  logic                      s1_valid_q;
  logic                      s1_op_q;
  logic signed [D_W-1:0]     s1_d_q [3];
  logic signed [D_W-1:0]     s1_d_d [3];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pt[0]  = in_i.x_in;
  assign pt[1]  = in_i.y_in;
  assign pt[2]  = in_i.z_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (in_i.op == OP_BACK) begin
        s1_d_d[i] = {pt[i][COORD_W-1], pt[i]};
      end else begin
        s1_d_d[i] = {pt[i][COORD_W-1], pt[i]} - {shift_q[i][COORD_W-1], shift_q[i]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q <= in_i.op;
      for (int i = 0; i < 3; i++) s1_d_q[i] <= s1_d_d[i];
    end
  end

  // ---------------- stage 2: nine products ----------------
  logic                     s2_valid_q;
  logic                     s2_op_q;
  logic signed [PROD_W-1:0] s2_prod_q [3][3];
  logic signed [PROD_W-1:0] s2_prod_d [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        // back mode walks the transpose
        if (s1_op_q == OP_BACK) begin
          s2_prod_d[i][j] = PROD_W'(mat[j][i] * s1_d_q[j]);
        end else begin
          s2_prod_d[i][j] = PROD_W'(mat[i][j] * s1_d_q[j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_op_q   <= s1_op_q;
      s2_prod_q <= s2_prod_d;
    end
  end

  // ---------------- stage 3: row sums ----------------
  logic                    s3_valid_q;
  logic                    s3_op_q;
  logic signed [SUM_W-1:0] s3_sum_q [3];
  logic signed [SUM_W-1:0] s3_sum_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_sum_d[i] = {{2{s2_prod_q[i][0][PROD_W-1]}}, s2_prod_q[i][0]}
                  + {{2{s2_prod_q[i][1][PROD_W-1]}}, s2_prod_q[i][1]}
                  + {{2{s2_prod_q[i][2][PROD_W-1]}}, s2_prod_q[i][2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_op_q  <= s2_op_q;
      s3_sum_q <= s3_sum_d;
    end
  end

  // ---------------- stage 4: scale down, translate (back) ----------------
  logic                    s4_valid_q;
  logic signed [ACC_W-1:0] s4_acc_q [3];
  logic signed [ACC_W-1:0] s4_acc_d [3];
  logic signed [SHR_W-1:0] scaled [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // dropping the fraction bits is an arithmetic shift, floor rounding
      scaled[i] = $signed(s3_sum_q[i][SUM_W-1:MAT_FRAC]);
      if (s3_op_q == OP_BACK) begin
        s4_acc_d[i] = {scaled[i][SHR_W-1], scaled[i]}
                    + {{(ACC_W-COORD_W){shift_q[i][COORD_W-1]}}, shift_q[i]};
      end else begin
        s4_acc_d[i] = {scaled[i][SHR_W-1], scaled[i]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      s4_acc_q <= s4_acc_d;
    end
  end

  // ---------------- stage 5: saturate ----------------
  logic                      done_q;
  point_out_t                result_q;
  point_out_t                result_d;
  logic signed [COORD_W-1:0] sat [3];
  logic [2:0]                clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // fits when every bit above the sign bit of the 32-bit range agrees
      if (s4_acc_q[i][ACC_W-1:COORD_W-1] == '0 ||
          s4_acc_q[i][ACC_W-1:COORD_W-1] == '1) begin
        sat[i]  = s4_acc_q[i][COORD_W-1:0];
        clip[i] = 1'b0;
      end else if (s4_acc_q[i][ACC_W-1]) begin
        sat[i]  = COORD_MIN;
        clip[i] = 1'b1;
      end else begin
        sat[i]  = COORD_MAX;
        clip[i] = 1'b1;
      end
    end
    result_d.x_out   = sat[0];
    result_d.y_out   = sat[1];
    result_d.z_out   = sat[2];
    result_d.clipped = |clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_valid_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // ---------------- checks ----------------
  `PRT_ASSERT_IMPL(a_done_has_item, clk_i, rst_ni, done_o, $past(start && !busy, 5))
  `PRT_ASSERT_NEXT(a_mult_no_drop, clk_i, rst_ni, s1_valid_q, s2_valid_q)
  `PRT_ASSERT_IMPL(a_clip_at_rail, clk_i, rst_ni, done_o && result_o.clipped, (result_o.x_out == COORD_MAX || result_o.x_out == COORD_MIN || result_o.y_out == COORD_MAX || result_o.y_out == COORD_MIN || result_o.z_out == COORD_MAX || result_o.z_out == COORD_MIN))

endmodule
